FILE: rtl/core/brs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants for the row shear engine
// Field widths, register indexes, result kinds and the per-pixel plan record.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int MAX_DIM    = 8192;
  localparam int DIM_W      = 14;  // width/height register, holds MAX_DIM
  localparam int CNT_W      = 13;  // column and row counters
  localparam int SLOPE_W    = 24;  // Q8.16 slope
  localparam int RUN_W      = 21;  // run lengths and max_shift
  localparam int ACC_W      = 37;  // row * slope, Q.16, below 2**37
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int PART_N     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_Q16  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SHIFT  = 2'd3;

  localparam logic [1:0] KIND_FILL = 2'd0;
  localparam logic [1:0] KIND_PIX  = 2'd1;
  localparam logic [1:0] KIND_PAD  = 2'd2;

  // result slots of one pixel, in emission order
  localparam int PART_LEAD  = 0;
  localparam int PART_PIX   = 1;
  localparam int PART_TRAIL = 2;
  localparam int PART_PAD   = 3;

  // accumulator is kept pre-biased by one half for round-half-up
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  typedef struct packed {
    logic [PART_N-1:0] parts;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic [RUN_W-1:0]  lead_len;
    logic [RUN_W-1:0]  trail_len;
    logic [1:0]        pad_len;
    logic              row_last;
  } plan_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/brs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_in_if: source pixel channel
// Valid/ready channel carrying one 24-bit source pixel per request.
// ----------------------------------------------------------------------------
interface brs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_blue;
  logic [7:0] pix_green;
  logic [7:0] pix_red;

  modport source (output valid, pix_blue, pix_green, pix_red, input ready);
  modport sink   (input valid, pix_blue, pix_green, pix_red, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/brs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_out_if: sheared row result channel
// Valid/ready channel carrying one fill run, pixel or padding result.
// ----------------------------------------------------------------------------
interface brs_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                item_kind;
  logic [brs_pkg::RUN_W-1:0] run_length;
  logic [7:0]                out_blue;
  logic [7:0]                out_green;
  logic [7:0]                out_red;
  logic                      row_end;
  logic                      last;

  modport source (output valid, item_kind, run_length, out_blue, out_green, out_red,
                  row_end, last, input ready);
  modport sink   (input valid, item_kind, run_length, out_blue, out_green, out_red,
                  row_end, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/brs_plan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_plan: configuration, row/column state and per-pixel result planning
// Holds the registers and counters; builds the result set for the pixel
// being accepted and advances the state on accept.
// ----------------------------------------------------------------------------
module brs_plan (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_fire,
  input  wire logic [7:0]                     pix_blue,
  input  wire logic [7:0]                     pix_green,
  input  wire logic [7:0]                     pix_red,
  output brs_pkg::plan_t                      plan
);

  logic [brs_pkg::DIM_W-1:0]   width_r;
  logic [brs_pkg::DIM_W-1:0]   height_r;
  logic [brs_pkg::SLOPE_W-1:0] slope_r;
  logic [brs_pkg::RUN_W-1:0]   shift_r;

  logic [brs_pkg::CNT_W-1:0]   col_r, col_nxt;
  logic [brs_pkg::CNT_W-1:0]   row_r, row_nxt;
  logic [brs_pkg::ACC_W-1:0]   racc_r, racc_nxt;

  logic [brs_pkg::DIM_W-1:0]   w_eff, h_eff;
  logic [brs_pkg::RUN_W-1:0]   lead;
  logic                        row_last, row_wrap, trail_pos;
  logic [1:0]                  pad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= brs_pkg::DIM_W'(1);
      height_r <= brs_pkg::DIM_W'(1);
      slope_r  <= '0;
      shift_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brs_pkg::REG_SRC_WIDTH:  width_r  <= cfg_data[brs_pkg::DIM_W-1:0];
        brs_pkg::REG_SRC_HEIGHT: height_r <= cfg_data[brs_pkg::DIM_W-1:0];
        brs_pkg::REG_SLOPE_Q16:  slope_r  <= cfg_data[brs_pkg::SLOPE_W-1:0];
        brs_pkg::REG_MAX_SHIFT:  shift_r  <= cfg_data[brs_pkg::RUN_W-1:0];
        default:                 slope_r  <= slope_r;
      endcase
    end
  end

  always_comb begin
    w_eff     = brs_pkg::clamp_dim(width_r);
    h_eff     = brs_pkg::clamp_dim(height_r);
    // bias already folded in, accumulator stays below 2**37 so no saturation
    lead      = racc_r[brs_pkg::ACC_W-1:brs_pkg::FRAC_W];
    row_last  = ({1'b0, col_r} + brs_pkg::DIM_W'(1)) >= w_eff;
    row_wrap  = ({1'b0, row_r} + brs_pkg::DIM_W'(1)) >= h_eff;
    trail_pos = shift_r > lead;
    // 3*(w+shift) padded to 4 bytes needs (w+shift) mod 4 bytes
    pad       = w_eff[1:0] + shift_r[1:0];

    plan.parts[brs_pkg::PART_LEAD]  = (col_r == '0) && (lead != '0);
    plan.parts[brs_pkg::PART_PIX]   = 1'b1;
    plan.parts[brs_pkg::PART_TRAIL] = row_last && trail_pos;
    plan.parts[brs_pkg::PART_PAD]   = row_last && (pad != 2'd0);
    plan.blue      = pix_blue;
    plan.green     = pix_green;
    plan.red       = pix_red;
    plan.lead_len  = lead;
    plan.trail_len = shift_r - lead;
    plan.pad_len   = pad;
    plan.row_last  = row_last;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    racc_nxt = racc_r;
    if (in_fire) begin
      if (row_last) begin
        col_nxt = '0;
        if (row_wrap) begin
          row_nxt  = '0;
          racc_nxt = brs_pkg::ROUND_HALF;
        end else begin
          row_nxt  = row_r + brs_pkg::CNT_W'(1);
          racc_nxt = racc_r + brs_pkg::ACC_W'(slope_r);
        end
      end else begin
        col_nxt = col_r + brs_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      racc_r <= brs_pkg::ROUND_HALF;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      racc_r <= racc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/brs_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_emit: entry register and output register
// Holds one planned pixel and hands out its results one per cycle into the
// output register while it is empty or being read, lowest pending slot first.
// ----------------------------------------------------------------------------
module brs_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire brs_pkg::plan_t plan,
  output logic                space,
  brs_out_if.source           out_chan
);

  logic                        e_valid_r, e_valid_nxt;
  logic [brs_pkg::PART_N-1:0]  e_mask_r, e_mask_nxt;
  brs_pkg::plan_t              e_r;

  logic                        o_valid_r, o_valid_nxt;
  logic [1:0]                  o_kind_r;
  logic [brs_pkg::RUN_W-1:0]   o_len_r;
  logic [7:0]                  o_blue_r, o_green_r, o_red_r;
  logic                        o_row_end_r, o_last_r;

  logic                        o_free, issue, e_done, sel_last;
  logic [brs_pkg::PART_N-1:0]  sel, rest;
  logic [1:0]                  sel_kind;
  logic [brs_pkg::RUN_W-1:0]   sel_len;
  logic [7:0]                  sel_blue, sel_green, sel_red;

  always_comb begin
    sel       = e_mask_r & (~e_mask_r + brs_pkg::PART_N'(1));  // lowest set bit
    rest      = e_mask_r & ~sel;
    sel_last  = (rest == '0);
    o_free    = !o_valid_r || out_chan.ready;
    issue     = e_valid_r && o_free;
    e_done    = issue && sel_last;
    space     = !e_valid_r || e_done;

    sel_kind  = brs_pkg::KIND_FILL;
    sel_len   = e_r.lead_len;
    sel_blue  = 8'hFF;
    sel_green = 8'hFF;
    sel_red   = 8'hFF;
    priority if (sel[brs_pkg::PART_PIX]) begin
      sel_kind  = brs_pkg::KIND_PIX;
      sel_len   = brs_pkg::RUN_W'(1);
      sel_blue  = e_r.blue;
      sel_green = e_r.green;
      sel_red   = e_r.red;
    end else if (sel[brs_pkg::PART_TRAIL]) begin
      sel_len   = e_r.trail_len;
    end else if (sel[brs_pkg::PART_PAD]) begin
      sel_kind  = brs_pkg::KIND_PAD;
      sel_len   = brs_pkg::RUN_W'(e_r.pad_len);
      sel_blue  = 8'h00;
      sel_green = 8'h00;
      sel_red   = 8'h00;
    end else begin
      sel_len   = e_r.lead_len;
    end
  end

  always_comb begin
    e_valid_nxt = e_valid_r;
    e_mask_nxt  = e_mask_r;
    if (load) begin
      e_valid_nxt = 1'b1;
      e_mask_nxt  = plan.parts;
    end else if (e_done) begin
      e_valid_nxt = 1'b0;
      e_mask_nxt  = '0;
    end else if (issue) begin
      e_mask_nxt  = rest;
    end

    o_valid_nxt = o_valid_r;
    if (issue) begin
      o_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      e_mask_r  <= '0;
      o_valid_r <= 1'b0;
    end else begin
      e_valid_r <= e_valid_nxt;
      e_mask_r  <= e_mask_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e_r <= plan;
    end
    if (issue) begin
      o_kind_r    <= sel_kind;
      o_len_r     <= sel_len;
      o_blue_r    <= sel_blue;
      o_green_r   <= sel_green;
      o_red_r     <= sel_red;
      o_row_end_r <= sel_last && e_r.row_last;
      o_last_r    <= sel_last;
    end
  end

  assign out_chan.valid      = o_valid_r;
  assign out_chan.item_kind  = o_kind_r;
  assign out_chan.run_length = o_len_r;
  assign out_chan.out_blue   = o_blue_r;
  assign out_chan.out_green  = o_green_r;
  assign out_chan.out_red    = o_red_r;
  assign out_chan.row_end    = o_row_end_r;
  assign out_chan.last       = o_last_r;

  // a held entry always has something left to send
  a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid_r |-> (e_mask_r != '0))
    else $error("entry held with no pending results");

  // the pixel itself goes out after any lead run and before any trailing part
  a_pix_order: assert property (@(posedge clk) disable iff (!rst_n)
    (e_valid_r && e_mask_r[brs_pkg::PART_LEAD]) |-> e_mask_r[brs_pkg::PART_PIX])
    else $error("lead run pending without its pixel");

  // a new pixel is only taken when the entry frees up
  a_load_space: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> space)
    else $error("pixel loaded over a busy entry");

  // a non-final result leaves the rest of its pixel in the entry
  a_keep_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && !sel_last) |=> (e_valid_r && out_chan.valid && !out_chan.last))
    else $error("entry dropped before its last result");

endmodule
`default_nettype wire

FILE: rtl/core/bmp_row_shear_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_row_shear_engine_unit: horizontal shear of a 24-bit pixel stream
// Emits per-row white lead runs, source pixels, trailing runs and padding.
// ----------------------------------------------------------------------------
// Source pixels enter on in_chan one request per cycle while the entry
// register is free; each becomes one to four results on out_chan: a white
// lead run of round(row*slope) pixels before a row's first pixel, the pixel
// itself, and after a row's last pixel a white run of max_shift minus the
// lead and then 0..3 zero padding bytes. Empty runs are skipped. The output
// port sends one result per cycle while out_chan is ready; a pixel holds the
// entry until its last result leaves, so mid-row pixels stream at one per
// cycle. The plan is captured in the entry register on accept, and its first
// result moves from there into the output register. Configuration must be
// written through cfg_we/cfg_index/cfg_data only while the block is idle,
// which the block itself does not enforce. There is no start-up clearing pass.
// ----------------------------------------------------------------------------
module bmp_row_shear_engine_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brs_pkg::CFG_DATA_W-1:0] cfg_data,
  brs_in_if.sink                              in_chan,
  brs_out_if.source                           out_chan
);

  brs_pkg::plan_t plan;
  logic           space;
  logic           in_fire;

  // input is taken whenever the entry register is free or emptying this cycle
  assign in_chan.ready = space;
  assign in_fire       = in_chan.valid && space;

  // counters, config and result planning for the incoming pixel
  brs_plan u_plan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .pix_blue  (in_chan.pix_blue),
    .pix_green (in_chan.pix_green),
    .pix_red   (in_chan.pix_red),
    .plan      (plan)
  );

  // holds the planned pixel, sends its results through the output register
  brs_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .plan     (plan),
    .space    (space),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

FILE: tb/bmp_row_shear_engine_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_row_shear_engine_unit_test: self-checking bench for the row shear engine
// Streams source pixels under changing row geometry, slope and extra width,
// predicts the lead, pixel, trailing and padding results of every request and
// checks each result in order against the engine's output channel.
// ----------------------------------------------------------------------------
module bmp_row_shear_engine_unit_test;
  import brs_pkg::*;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // one result as it should leave the engine
  typedef struct {
    logic [1:0]       kind;
    logic [RUN_W-1:0] len;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic             row_end;
    logic             last;
  } shear_result_t;

  // one source pixel request, with the idle cycles the sender waits first
  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    int         gap;
  } src_pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  brs_in_if  pix_ch ();
  brs_out_if res_ch ();

  bmp_row_shear_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (pix_ch),
    .out_chan  (res_ch)
  );

  // mirror of the register file, updated as the bench writes it
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [SLOPE_W-1:0] slope_reg;
  logic [RUN_W-1:0]   shift_reg;

  // bench copy of the row position; the offset is row * slope in Q.16
  int          col_pos;
  int          row_pos;
  logic [39:0] row_offset_acc;

  src_pixel_t    pixel_queue[$];
  shear_result_t pending_results[$];
  shear_result_t want;

  int          px_queued;
  int          px_accepted;
  int          mismatch_count;
  logic        px_taken;
  logic [15:0] stall_pattern;
  logic [3:0]  stall_phase;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------- prediction
  // A width or height of 0 behaves as 1, anything above MAX_DIM as MAX_DIM.
  function automatic int effective_dim(logic [DIM_W-1:0] v);
    int d;
    d = int'(v);
    if (d == 0) begin
      d = 1;
    end else if (d > MAX_DIM) begin
      d = MAX_DIM;
    end
    return d;
  endfunction

  // Expected results of one accepted source pixel, appended in order.
  function automatic void shear_pixel(logic [7:0] blue, logic [7:0] green,
                                      logic [7:0] red);
    int               w;
    int               h;
    logic [39:0]      lead_full;
    logic [RUN_W-1:0] lead;
    logic [RUN_W-1:0] trail;
    logic [31:0]      new_w;
    logic [1:0]       pad;
    shear_result_t    res[$];
    w = effective_dim(width_reg);
    h = effective_dim(height_reg);
    // round half up, saturating at the run width
    lead_full = (row_offset_acc + 40'h8000) >> FRAC_W;
    lead = (lead_full > 40'(RUN_MAX)) ? RUN_MAX : lead_full[RUN_W-1:0];

    if (col_pos == 0 && lead != '0) begin
      res.push_back('{KIND_FILL, lead, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0});
    end
    res.push_back('{KIND_PIX, RUN_W'(1), blue, green, red, 1'b0, 1'b0});

    // a column at or past the width closes the row, also after a width cut
    if (col_pos + 1 >= w) begin
      trail = (shift_reg > lead) ? shift_reg - lead : '0;
      new_w = 32'(w) + 32'(shift_reg);
      // bytes up to the next multiple of 4: low bits of -(3 * new_w)
      pad = 2'(32'd0 - 32'd3 * new_w);
      if (trail != '0) begin
        res.push_back('{KIND_FILL, trail, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0});
      end
      if (pad != '0) begin
        res.push_back('{KIND_PAD, RUN_W'(pad), 8'h00, 8'h00, 8'h00, 1'b0, 1'b0});
      end
      res[res.size()-1].row_end = 1'b1;
      col_pos = 0;
      row_pos++;
      // new slope applies from the next row on, on top of what is there
      row_offset_acc = row_offset_acc + 40'(slope_reg);
      if (row_pos >= h) begin
        row_pos = 0;
        row_offset_acc = '0;
      end
    end else begin
      col_pos++;
    end
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  // ------------------------------------------------------------- checking
  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      report_mismatch($sformatf("%s expected %0d, got %0d", name, want_v, got_v));
    end
  endtask

  // Monitor: both channels are sampled on the rising edge. An accepted pixel
  // request is predicted right away; an accepted result is matched against
  // the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      px_taken <= 1'b0;
    end else begin
      px_taken <= pix_ch.valid && pix_ch.ready;
      if (pix_ch.valid && pix_ch.ready) begin
        shear_pixel(pix_ch.pix_blue, pix_ch.pix_green, pix_ch.pix_red);
        px_accepted++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d len %0d with none pending",
                                    res_ch.item_kind, res_ch.run_length));
        end else begin
          want = pending_results.pop_front();
          check_field("item_kind", 32'(want.kind), 32'(res_ch.item_kind));
          check_field("run_length", 32'(want.len), 32'(res_ch.run_length));
          check_field("out_blue", 32'(want.blue), 32'(res_ch.out_blue));
          check_field("out_green", 32'(want.green), 32'(res_ch.out_green));
          check_field("out_red", 32'(want.red), 32'(res_ch.out_red));
          check_field("row_end", 32'(want.row_end), 32'(res_ch.row_end));
          check_field("last", 32'(want.last), 32'(res_ch.last));
        end
      end
    end
  end

  // --------------------------------------------------------------- driver
  // Inputs move on the falling edge. A new request is loaded once the current
  // one was taken; a request's gap is spent first as idle cycles, which gives
  // the sender its bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || px_taken) begin
      if (pixel_queue.size() == 0) begin
        pix_ch.valid <= 1'b0;
      end else if (pixel_queue[0].gap != 0) begin
        pixel_queue[0].gap = pixel_queue[0].gap - 1;
        pix_ch.valid <= 1'b0;
      end else begin
        pix_ch.valid     <= 1'b1;
        pix_ch.pix_blue  <= pixel_queue[0].blue;
        pix_ch.pix_green <= pixel_queue[0].green;
        pix_ch.pix_red   <= pixel_queue[0].red;
        pixel_queue.delete(0);
      end
    end
  end

  // Receiver stalls follow the pattern in stall_pattern, redrawn each time it
  // runs out: no stall, random, alternating ready, or a long stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_phase  <= '0;
    end else begin
      if (stall_phase == '0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'hFFFF;
          1:       stall_pattern = 16'($urandom);
          2:       stall_pattern = 16'h5555;
          default: stall_pattern = 16'h00FF;
        endcase
      end
      res_ch.ready <= stall_pattern[stall_phase];
      stall_phase  <= stall_phase + 4'd1;
    end
  end

  // ------------------------------------------------------------- stimulus
  // Queue one pixel request; called only right after a rising edge.
  function automatic void push_pixel(logic [7:0] blue, logic [7:0] green,
                                     logic [7:0] red, int gap);
    pixel_queue.push_back('{blue, green, red, gap});
    px_queued++;
  endfunction

  // Register write on the falling edge; the mirror follows at once since
  // the engine is idle whenever this runs.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SRC_WIDTH:  width_reg  = val[DIM_W-1:0];
      REG_SRC_HEIGHT: height_reg = val[DIM_W-1:0];
      REG_SLOPE_Q16:  slope_reg  = val[SLOPE_W-1:0];
      REG_MAX_SHIFT:  shift_reg  = val[RUN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every queued request taken and every expected result seen. Every pixel
  // yields at least one result, so nothing can still be in flight here.
  task automatic wait_idle();
    do @(negedge clk);
    while (px_accepted != px_queued || pending_results.size() != 0);
  endtask

  initial begin
    int  n_left;
    int  phase_len;
    int  burst_left;
    int  gap;
    bit  bursty;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    pix_ch.valid     = 1'b0;
    pix_ch.pix_blue  = '0;
    pix_ch.pix_green = '0;
    pix_ch.pix_red   = '0;
    res_ch.ready     = 1'b0;
    width_reg        = DIM_W'(1);
    height_reg       = DIM_W'(1);
    slope_reg        = '0;
    shift_reg        = '0;
    col_pos          = 0;
    row_pos          = 0;
    row_offset_acc   = '0;
    px_queued        = 0;
    px_accepted      = 0;
    mismatch_count   = 0;
    px_taken         = 1'b0;
    stall_pattern    = 16'hFFFF;
    stall_phase      = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry: one-pixel rows, no shear, 3-byte rows need 1 pad byte.
    @(posedge clk);
    push_pixel(8'h00, 8'h00, 8'h00, 0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 0);
    push_pixel(8'hAA, 8'h55, 8'h0F, 2);
    wait_idle();

    // One full frame of 3x4 at slope 1.5: leads 0, 2 (half rounds up), 3, 5,
    // trailing runs down from 6, pad byte on each 9-pixel row, wrap to row 0.
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(4));
    write_reg(REG_SLOPE_Q16, 24'h018000);
    write_reg(REG_MAX_SHIFT, CFG_DATA_W'(6));
    @(posedge clk);
    for (int i = 0; i < 12; i++) begin
      push_pixel(8'(i * 21), 8'(255 - i), 8'(i << 4), 0);
    end
    wait_idle();

    // Largest slope with no extra width: the lead overruns max_shift, so no
    // trailing run; then a zero height, which acts as one row.
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(2));
    write_reg(REG_SLOPE_Q16, 24'hFFFFFF);
    write_reg(REG_MAX_SHIFT, CFG_DATA_W'(0));
    @(posedge clk);
    push_pixel(8'h12, 8'h34, 8'h56, 0);
    push_pixel(8'hED, 8'hCB, 8'hA9, 0);
    wait_idle();
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(0));
    @(posedge clk);
    push_pixel(8'h80, 8'h01, 8'h7F, 0);
    wait_idle();

    // Oversized width and height clamp to MAX_DIM, largest extra width. Then
    // the width is cut mid-row (row ends at once) and the height is cut below
    // the current row (frame wraps after this row).
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(16383));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(16383));
    write_reg(REG_SLOPE_Q16, CFG_DATA_W'(1));
    write_reg(REG_MAX_SHIFT, CFG_DATA_W'(2097151));
    @(posedge clk);
    repeat (3) push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 0);
    wait_idle();
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(2));
    @(posedge clk);
    repeat (2) push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1);
    wait_idle();
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(1));
    @(posedge clk);
    repeat (2) push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 0);
    wait_idle();

    // Random phases: each rewrites some registers while idle (often mid-row
    // or mid-frame), then streams random pixels, mostly in short rows so that
    // row edges come often. Each phase drains fully before the next writes.
    n_left = 460;
    while (n_left > 0) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_SRC_WIDTH, CFG_DATA_W'(0));
          1:       write_reg(REG_SRC_WIDTH, CFG_DATA_W'($urandom_range(8000, 16383)));
          2:       write_reg(REG_SRC_WIDTH, CFG_DATA_W'($urandom_range(13, 40)));
          default: write_reg(REG_SRC_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(0));
          1:       write_reg(REG_SRC_HEIGHT, CFG_DATA_W'($urandom_range(8193, 16383)));
          2:       write_reg(REG_SRC_HEIGHT, CFG_DATA_W'($urandom_range(1, 8192)));
          default: write_reg(REG_SRC_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(REG_SLOPE_Q16, CFG_DATA_W'(0));
          1:       write_reg(REG_SLOPE_Q16, 24'hFFFFFF);
          2:       write_reg(REG_SLOPE_Q16, CFG_DATA_W'($urandom));
          default: write_reg(REG_SLOPE_Q16, CFG_DATA_W'($urandom_range(0, 24'h03FFFF)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(REG_MAX_SHIFT, CFG_DATA_W'(0));
          1:       write_reg(REG_MAX_SHIFT, CFG_DATA_W'(2097151));
          2:       write_reg(REG_MAX_SHIFT, CFG_DATA_W'(21'($urandom)));
          default: write_reg(REG_MAX_SHIFT, CFG_DATA_W'($urandom_range(0, 24)));
        endcase
      end

      phase_len = $urandom_range(10, 50);
      if (phase_len > n_left) phase_len = n_left;
      // one phase in four streams back to back with no sender gaps
      bursty     = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      @(posedge clk);
      repeat (phase_len) begin
        gap = 0;
        if (bursty && burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap        = $urandom_range(1, 8);
        end
        if (bursty) burst_left--;
        push_pixel(8'($urandom), 8'($urandom), 8'($urandom), gap);
      end
      n_left -= phase_len;
      wait_idle();
    end

    // leave room for any stray result to show up
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS bmp_row_shear_engine_unit");
    end else begin
      $display("FAIL bmp_row_shear_engine_unit");
    end
    $finish;
  end

  // Hang guard: fails the run if it has not finished before this delay.
  initial begin
    #500_000;
    $display("FAIL bmp_row_shear_engine_unit");
    $finish;
  end

endmodule
